/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock and active-low reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Same, on the default clock and reset names.
`define ASSERT_DEF(lbl, prop) `ASSERT_AT(lbl, clk_i, rst_ni, prop)

`endif

/* hw/rtl/bra_pkg.sv */
// Package of the bitmap run allocator: codes, constants and helper functions.
`default_nettype none

package bra_pkg;

  localparam int MAP_BYTES = 512;

  localparam int CmdW    = 2;
  localparam int IndexW  = 32;
  localparam int CountW  = 13;
  localparam int StatusW = 2;
  localparam int LengthW = 10;

  localparam int InDataW  = 48;
  localparam int OutDataW = 40;

  localparam logic [9:0] LENGTH_RESET = 10'd512;

  typedef enum logic [CmdW-1:0] {
    CMD_TEST  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_ALLOC = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_NOFIT = 2'd2,
    ST_ZERO  = 2'd3
  } status_e;

  // Configuration register indexes.
  localparam logic CFG_BASE   = 1'b0;
  localparam logic CFG_LENGTH = 1'b1;

  // Byte mask with bits lo through hi set.
  function automatic logic [7:0] run_mask(input logic [2:0] lo, input logic [2:0] hi);
    logic [7:0] m;
    m = '0;
    for (int k = 0; k < 8; k++) begin
      m[k] = (3'(k) >= lo) && (3'(k) <= hi);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/bra_map.sv */
// Occupancy memory: one write port and one registered read port, one byte per entry.
`default_nettype none

module bra_map #(
  parameter int Depth = bra_pkg::MAP_BYTES,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [7:0]       wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/bra_scan.sv */
// Byte scan unit: extends the free-run count over one map byte and finds the first fit.
`default_nettype none

module bra_scan (
  input  wire logic [7:0]                  byte_i,
  input  wire logic [bra_pkg::CountW-1:0]  run_i,
  input  wire logic [bra_pkg::CountW-1:0]  cnt_i,
  output logic                             hit_o,
  output logic      [2:0]                  pos_o,
  output logic      [bra_pkg::CountW-1:0]  run_o
);

  localparam int RunW = bra_pkg::CountW + 1;

  logic [3:0]      tz    [8];
  logic [7:0]      allf;
  logic [RunW-1:0] run_j [8];
  logic [7:0]      fit;

  // tz counts the free bits ending at each position inside the byte; allf marks
  // positions where every bit up to and including it is free, so the incoming run continues.
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      if (j == 0) begin
        tz[j]   = byte_i[j] ? 4'd0 : 4'd1;
        allf[j] = ~byte_i[j];
      end else begin
        tz[j]   = byte_i[j] ? 4'd0 : tz[j-1] + 4'd1;
        allf[j] = allf[j-1] & ~byte_i[j];
      end
      run_j[j] = allf[j] ? RunW'(run_i) + RunW'(j + 1) : RunW'(tz[j]);
      fit[j]   = run_j[j] >= RunW'(cnt_i);
    end
  end

  always_comb begin
    hit_o = 1'b0;
    pos_o = 3'd0;
    for (int j = 7; j >= 0; j--) begin
      if (fit[j]) begin
        hit_o = 1'b1;
        pos_o = 3'(j);
      end
    end
  end

  assign run_o = run_j[7][bra_pkg::CountW-1:0];

endmodule

`default_nettype wire

/* hw/rtl/bitmap_run_allocator.sv */
// Top level of the bitmap run allocator: sequencer, shared adder and result register.
//
//   Channel   Direction  Handshake              Payload
//   s_axis    in         tvalid / tready        cmd, bit_index, run_length
//   m_axis    out        tvalid / tready        status, bit_value, run_start
//   cfg       in         cfg_valid / cfg_ready  register index, write data
//
// Test, set and clear pass from acceptance through a range check on the shared adder,
// a read-modify-write of the map byte, then the output register. Allocate scans map
// bytes until the run fits and then marks the bytes it covers, or scans the whole map
// length when nothing fits; the single map read port, one byte a cycle, paces both passes.
// After reset a clearing pass writes every map byte before the first item is taken.
// A stalled output holds the next result in the sequencer.
`default_nettype none

module bitmap_run_allocator #(
  parameter int MapBytes = bra_pkg::MAP_BYTES
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [1:0] cmd, [33:2] bit_index, [46:34] run_length, [47] zero
  input  wire logic [bra_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // [1:0] status, [2] bit_value, [34:3] run_start, [39:35] zero
  output logic      [bra_pkg::OutDataW-1:0] m_axis_tdata_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic                         cfg_index_i,
  input  wire logic [31:0]                  cfg_data_i
);

  localparam int AddrW = (MapBytes > 1) ? $clog2(MapBytes) : 1;
  localparam int PtrW  = $clog2(MapBytes + 1);
  localparam int BitW  = AddrW + 3;
  localparam int CntW  = bra_pkg::CountW;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_FIX   = 4'd5;
  localparam logic [3:0] S_START = 4'd6;
  localparam logic [3:0] S_MARK  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_q, state_d;

  logic [31:0]               base_q;
  logic [bra_pkg::LengthW-1:0] length_q;
  logic [PtrW-1:0]           len_eff;

  // Item registers.
  bra_pkg::cmd_e   cmd_q;
  logic [31:0]     idx_q;
  logic [CntW-1:0] cnt_q, cnt_m1_q;
  logic [PtrW-1:0] len_q;

  // Sequencer registers.
  logic [PtrW-1:0]  clr_ptr_q, clr_ptr_d;
  logic [PtrW-1:0]  ptr_q, ptr_d;
  logic             pend_q, pend_d;
  logic [AddrW-1:0] proc_q, proc_d;
  logic [CntW-1:0]  run_q, run_d;
  logic [BitW-1:0]  rel_q, rel_d;
  logic [BitW-1:0]  last_q, last_d;
  logic [BitW-1:0]  found_q, found_d;

  bra_pkg::status_e res_status_q, res_status_d;
  logic             res_bit_q, res_bit_d;
  logic [31:0]      res_start_q, res_start_d;

  logic             m_valid_q, m_valid_d;
  bra_pkg::status_e out_status_q;
  logic             out_bit_q;
  logic [31:0]      out_start_q;

  // Shared adder.
  logic [31:0] add_a, add_b;
  logic        add_cin;
  logic [32:0] sum;
  logic        in_range;

  // Map ports.
  logic             map_we;
  logic [AddrW-1:0] map_waddr, map_raddr;
  logic [7:0]       map_wdata, map_rdata;

  // Scan unit.
  logic            scan_hit;
  logic [2:0]      scan_pos;
  logic [CntW-1:0] scan_run;

  logic       s_acc, out_free;
  logic [2:0] mk_lo, mk_hi;
  logic [7:0] bit_m;
  logic [PtrW-1:0] last_byte;

  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;

  always_comb begin
    if (32'(length_q) > 32'(MapBytes)) begin
      len_eff = PtrW'(MapBytes);
    end else begin
      len_eff = PtrW'(length_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      length_q <= bra_pkg::LENGTH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bra_pkg::CFG_BASE:   base_q   <= cfg_data_i;
        bra_pkg::CFG_LENGTH: length_q <= cfg_data_i[bra_pkg::LengthW-1:0];
        default:             base_q   <= base_q;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    unique case (state_q)
      S_CHK: begin
        add_a   = idx_q;
        add_b   = ~base_q;
        add_cin = 1'b1;
      end
      S_FIX: begin
        add_a   = 32'(last_q);
        add_b   = ~32'(cnt_m1_q);
        add_cin = 1'b1;
      end
      default: begin
        add_a   = base_q;
        add_b   = 32'(found_q);
        add_cin = 1'b0;
      end
    endcase
  end

  assign sum      = {1'b0, add_a} + {1'b0, add_b} + 33'(add_cin);
  // A carry out means no borrow, so the index is at or above the base.
  assign in_range = sum[32] && (sum[31:3] < 29'(len_q));

  assign last_byte = PtrW'(last_q[BitW-1:3]);
  assign mk_lo     = (proc_q == found_q[BitW-1:3]) ? found_q[2:0] : 3'd0;
  assign mk_hi     = (proc_q == last_q[BitW-1:3]) ? last_q[2:0] : 3'd7;
  assign bit_m     = 8'd1 << rel_q[2:0];

  always_comb begin
    state_d      = state_q;
    clr_ptr_d    = clr_ptr_q;
    ptr_d        = ptr_q;
    pend_d       = pend_q;
    proc_d       = proc_q;
    run_d        = run_q;
    rel_d        = rel_q;
    last_d       = last_q;
    found_d      = found_q;
    res_status_d = res_status_q;
    res_bit_d    = res_bit_q;
    res_start_d  = res_start_q;
    m_valid_d    = m_valid_q && !m_axis_tready_i;
    map_we       = 1'b0;
    map_waddr    = proc_q;
    map_wdata    = map_rdata;
    map_raddr    = ptr_q[AddrW-1:0];

    unique case (state_q)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_ptr_q[AddrW-1:0];
        map_wdata = 8'd0;
        clr_ptr_d = clr_ptr_q + PtrW'(1);
        if (clr_ptr_q == PtrW'(MapBytes - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_acc) begin
          res_status_d = bra_pkg::ST_OK;
          res_bit_d    = 1'b0;
          res_start_d  = '0;
          ptr_d        = '0;
          pend_d       = 1'b0;
          run_d        = '0;
          if (bra_pkg::cmd_e'(s_axis_tdata_i[1:0]) != bra_pkg::CMD_ALLOC) begin
            state_d = S_CHK;
          end else if (s_axis_tdata_i[46:34] == '0) begin
            res_status_d = bra_pkg::ST_ZERO;
            state_d      = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_CHK: begin
        rel_d     = sum[BitW-1:0];
        map_raddr = sum[BitW-1:3];
        if (in_range) begin
          state_d = S_RD;
        end else begin
          res_status_d = bra_pkg::ST_RANGE;
          state_d      = S_DONE;
        end
      end
      S_RD: begin
        map_waddr = rel_q[BitW-1:3];
        case (cmd_q)
          bra_pkg::CMD_TEST: res_bit_d = map_rdata[rel_q[2:0]];
          bra_pkg::CMD_SET: begin
            map_we    = 1'b1;
            map_wdata = map_rdata | bit_m;
          end
          default: begin
            map_we    = 1'b1;
            map_wdata = map_rdata & ~bit_m;
          end
        endcase
        state_d = S_DONE;
      end
      S_SCAN: begin
        // Reads are issued one byte a cycle; the byte read last cycle is scanned now.
        if (pend_q) begin
          run_d = scan_run;
        end
        if (ptr_q < len_q) begin
          pend_d = 1'b1;
          proc_d = ptr_q[AddrW-1:0];
          ptr_d  = ptr_q + PtrW'(1);
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q && scan_hit) begin
          last_d  = {proc_q, scan_pos};
          state_d = S_FIX;
        end else if (!pend_q && (ptr_q == len_q)) begin
          res_status_d = bra_pkg::ST_NOFIT;
          state_d      = S_DONE;
        end
      end
      S_FIX: begin
        found_d = sum[BitW-1:0];
        state_d = S_START;
      end
      S_START: begin
        res_start_d = sum[31:0];
        ptr_d       = PtrW'(found_q[BitW-1:3]);
        pend_d      = 1'b0;
        state_d     = S_MARK;
      end
      S_MARK: begin
        if (pend_q) begin
          map_we    = 1'b1;
          map_wdata = map_rdata | bra_pkg::run_mask(mk_lo, mk_hi);
        end
        if (ptr_q <= last_byte) begin
          pend_d = 1'b1;
          proc_d = ptr_q[AddrW-1:0];
          ptr_d  = ptr_q + PtrW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_ptr_q <= '0;
      ptr_q     <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_ptr_q <= clr_ptr_d;
      ptr_q     <= ptr_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    proc_q       <= proc_d;
    run_q        <= run_d;
    rel_q        <= rel_d;
    last_q       <= last_d;
    found_q      <= found_d;
    res_status_q <= res_status_d;
    res_bit_q    <= res_bit_d;
    res_start_q  <= res_start_d;
    if (s_acc) begin
      cmd_q    <= bra_pkg::cmd_e'(s_axis_tdata_i[1:0]);
      idx_q    <= s_axis_tdata_i[33:2];
      cnt_q    <= s_axis_tdata_i[46:34];
      cnt_m1_q <= s_axis_tdata_i[46:34] - CntW'(1);
      len_q    <= len_eff;
    end
    if ((state_q == S_DONE) && out_free) begin
      out_status_q <= res_status_q;
      out_bit_q    <= res_bit_q;
      out_start_q  <= res_start_q;
    end
  end

  bra_map #(
    .Depth (MapBytes),
    .AddrW (AddrW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  bra_scan u_scan (
    .byte_i (map_rdata),
    .run_i  (run_q),
    .cnt_i  (cnt_q),
    .hit_o  (scan_hit),
    .pos_o  (scan_pos),
    .run_o  (scan_run)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_start_q, out_bit_q, out_status_q};

endmodule

`default_nettype wire

/* hw/rtl/bra_checker.sv */
// Port-level checker for the bitmap run allocator, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module bra_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tvalid_i,
  input wire logic                         s_axis_tready_o,
  input wire logic                         m_axis_tvalid_o,
  input wire logic                         m_axis_tready_i,
  input wire logic [bra_pkg::OutDataW-1:0] m_axis_tdata_o
);

  logic in_acc;
  logic out_stall;
  logic out_fail;

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_fail  = m_axis_tvalid_o && (m_axis_tdata_o[1:0] != bra_pkg::ST_OK);

  // A stalled result keeps its contents.
  `ASSERT_DEF(a_out_hold, out_stall |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))

  // One item at a time: no item is taken in the cycle right after another.
  `ASSERT_DEF(a_one_item, in_acc |=> !s_axis_tready_o)

  // A result never appears in the cycle after its item was accepted.
  `ASSERT_DEF(a_no_instant, in_acc && !m_axis_tvalid_o |=> !m_axis_tvalid_o)

  // A failed command carries neither a bit value nor a run start.
  `ASSERT_DEF(a_fail_zero, out_fail |-> m_axis_tdata_o[34:2] == '0)

endmodule

bind bitmap_run_allocator bra_checker u_bra_checker (.*);

`default_nettype wire
